FILE: rtl/bde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bde_pkg;

   localparam int COORD_W  = 32;
   localparam int CNT_W    = 7;
   localparam int WEIGHT_W = 16;
   localparam int STEP_W   = $clog2(WEIGHT_W);
   // w*(prev-cur) with w < 2**WEIGHT_W and a difference one bit wider than a coordinate
   localparam int ACC_W    = COORD_W + WEIGHT_W + 1;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
      logic                      last_point;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_BLEND,
      ST_PASS
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/bezier_degree_elevation.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_payload_type: point_x/y/z
// rsp_      out        rsp_valid/rsp_stall  rsp_payload_type: out_x/y/z, last_point
// csr_      in         csr_write_enable     csr_write_data: point_count
//
// First point of a curve and every point when point_count is 1: ST_PASS only.
// Other points: ST_DIVIDE then ST_BLEND, and ST_PASS too for the final point
// (two results). The serial restoring divider makes one weight bit per cycle,
// and each bit is folded into the blend accumulators MSB first as it appears.
// Synchronous active-high reset: point_count returns to 4, curve position to 0.
// A stalled result sits in the output register; the next transaction is still
// taken and waits in the working registers until the output register frees.

module bezier_degree_elevation
   import bde_pkg::*;
#(
   parameter int MAX_POINTS = 64
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_stall,
   input  wire req_payload_type req_payload,
   output      logic            rsp_valid,
   input  wire logic            rsp_stall,
   output      rsp_payload_type rsp_payload,
   input  wire logic            csr_write_enable,
   input  wire logic [CNT_W-1:0] csr_write_data
);

   localparam int CNT_MAX = (1 << CNT_W) - 1;
   localparam int CAP     = (MAX_POINTS > CNT_MAX) ? CNT_MAX : MAX_POINTS;
   localparam logic [CNT_W-1:0] CAP_N = CNT_W'(CAP);
   localparam logic [CNT_W-1:0] ONE_N = CNT_W'(1);
   localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(4);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] index_ff, index_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic final_ff, final_in;
   logic last_ff, last_in;
   logic signed [COORD_W-1:0] prev_ff [3];
   logic signed [COORD_W-1:0] prev_in [3];
   logic signed [COORD_W-1:0] cur_ff [3];
   logic signed [COORD_W-1:0] cur_in [3];
   logic signed [COORD_W:0]   diff_ff [3];
   logic signed [COORD_W:0]   diff_in [3];
   logic signed [ACC_W-1:0]   acc_ff [3];
   logic signed [ACC_W-1:0]   acc_in [3];
   logic rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic signed [COORD_W-1:0] point [3];
   logic [COORD_W-1:0] blended [3];
   logic [CNT_W-1:0] count_nz;
   logic [CNT_W-1:0] n_eff;
   logic [CNT_W-1:0] i_clamp;
   logic [CNT_W:0]   rem2;
   logic [CNT_W:0]   rem_sub;
   logic             qbit;
   logic             accept;
   logic             slot_free;

   assign point[0] = req_payload.point_x;
   assign point[1] = req_payload.point_y;
   assign point[2] = req_payload.point_z;

   assign count_nz = (count_ff == '0) ? ONE_N : count_ff;
   assign n_eff    = (count_nz > CAP_N) ? CAP_N : count_nz;
   assign i_clamp  = (index_ff > n_eff - ONE_N) ? (n_eff - ONE_N) : index_ff;

   // restoring divide step: remainder always stays below n
   assign rem2    = {rem_ff, 1'b0};
   assign rem_sub = rem2 - {1'b0, n_ff};
   assign qbit    = (rem2 >= {1'b0, n_ff});

   // round half up: floor((acc + 2^15) / 2^16) = acc[hi] + acc[15]
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         blended[k] = cur_ff[k] + acc_ff[k][COORD_W+WEIGHT_W-1:WEIGHT_W]
                      + {{(COORD_W-1){1'b0}}, acc_ff[k][WEIGHT_W-1]};
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      index_in     = index_ff;
      n_in         = n_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      final_in     = final_ff;
      last_in      = last_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      diff_in      = diff_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_write_enable) begin
         count_in = csr_write_data;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               for (int k = 0; k < 3; k++) begin
                  cur_in[k]  = point[k];
                  prev_in[k] = point[k];
                  diff_in[k] = {prev_ff[k][COORD_W-1], prev_ff[k]}
                               - {point[k][COORD_W-1], point[k]};
                  acc_in[k]  = '0;
               end
               rem_in  = i_clamp;
               n_in    = n_eff;
               step_in = '1;
               if (n_eff == ONE_N) begin
                  last_in  = 1'b1;
                  index_in = '0;
                  state_in = ST_PASS;
               end else if (i_clamp == '0) begin
                  last_in  = 1'b0;
                  index_in = ONE_N;
                  state_in = ST_PASS;
               end else begin
                  final_in = (i_clamp == n_eff - ONE_N);
                  index_in = (i_clamp == n_eff - ONE_N) ? '0 : (i_clamp + ONE_N);
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            rem_in = qbit ? rem_sub[CNT_W-1:0] : rem2[CNT_W-1:0];
            // Horner: weight bits arrive MSB first
            for (int k = 0; k < 3; k++) begin
               acc_in[k] = (acc_ff[k] <<< 1)
                           + (qbit ? {{(ACC_W-COORD_W-1){diff_ff[k][COORD_W]}}, diff_ff[k]}
                                   : {ACC_W{1'b0}});
            end
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = ST_BLEND;
            end
         end
         ST_BLEND: begin
            if (slot_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.out_x       = blended[0];
               rsp_data_in.out_y       = blended[1];
               rsp_data_in.out_z       = blended[2];
               rsp_data_in.last_point  = 1'b0;
               last_in                 = 1'b1;
               state_in                = final_ff ? ST_PASS : ST_IDLE;
            end
         end
         ST_PASS: begin
            if (slot_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.out_x      = cur_ff[0];
               rsp_data_in.out_y      = cur_ff[1];
               rsp_data_in.out_z      = cur_ff[2];
               rsp_data_in.last_point = last_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= COUNT_RESET;
         index_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            prev_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         index_ff     <= index_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      final_ff    <= final_in;
      last_ff     <= last_in;
      cur_ff      <= cur_in;
      diff_ff     <= diff_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

`default_nettype wire

FILE: rtl/bde_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bde_checker
   import bde_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_stall,
   input wire logic            rsp_valid,
   input wire logic            rsp_stall,
   input wire rsp_payload_type rsp_payload
);

   // one transaction in work at a time: the cycle after a take is always busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while previous transaction still in work");

   a_reset_clean: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("block not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result dropped or changed");

endmodule

bind bezier_degree_elevation bde_checker u_bde_checker (.*);

`default_nettype wire
